### hw/rtl/fpalu_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Operation codes, widths and pipeline sideband shared by the ALU modules.
// ----------------------------------------------------------------------------
package fpalu_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned OpW       = 3;
  localparam int unsigned FracBitsD = 8;

  typedef enum logic [OpW-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MIN = 3'd4,
    OP_MAX = 3'd5
  } op_t;

  // Sideband that travels beside the divider and multiplier.
  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [WordW-1:0] simple;
    logic             lt;
    logic             eq;
    logic             gt;
    logic             dz;
  } side_t;

endpackage

### hw/rtl/fpalu_mul.sv
// ----------------------------------------------------------------------------
// Fixed-point multiplier
// Two-stage 32x32 signed multiply with ceiling rescale by 2^FRAC_BITS.
// The product is registered in p_r and the rescaled result in prod_r.
// ----------------------------------------------------------------------------
module fpalu_mul #(
  parameter int unsigned FRAC_BITS = fpalu_pkg::FracBitsD
) (
  input  logic                           clk,
  input  logic signed [fpalu_pkg::WordW-1:0] a,
  input  logic signed [fpalu_pkg::WordW-1:0] b,
  output logic        [fpalu_pkg::WordW-1:0] prod
);
  import fpalu_pkg::*;

  localparam int unsigned PW = 2*WordW;

  logic signed [PW-1:0] p_r;
  logic signed [PW-1:0] s;
  logic        [WordW-1:0] prod_r;

  always_ff @(posedge clk) begin
    p_r <= PW'(a) * PW'(b);
  end

  // Add bias and arithmetic shift right: ceil division.
  assign s = p_r + PW'((64'd1 << FRAC_BITS) - 64'd1);

  always_ff @(posedge clk) begin
    prod_r <= WordW'(s >>> FRAC_BITS);
  end

  assign prod = prod_r;
endmodule

### hw/rtl/fpalu_div.sv
// ----------------------------------------------------------------------------
// Fixed-point divider
// Pipelined restoring divider, one quotient bit per stage, ceiling rounding.
// ----------------------------------------------------------------------------
module fpalu_div #(
  parameter int unsigned FRAC_BITS = fpalu_pkg::FracBitsD
) (
  input  logic                               clk,
  input  logic signed [fpalu_pkg::WordW-1:0] a,
  input  logic signed [fpalu_pkg::WordW-1:0] b,
  output logic        [fpalu_pkg::WordW-1:0] quot
);
  import fpalu_pkg::*;

  localparam int unsigned NW = WordW + FRAC_BITS;  // dividend magnitude width
  localparam int unsigned DW = WordW;               // divisor magnitude width
  localparam int unsigned RW = DW + 1;

  typedef struct packed {
    logic [NW-1:0] n;     // shifts out dividend, shifts in quotient
    logic [RW-1:0] r;
    logic [DW-1:0] d;
    logic          same;  // result sign positive
  } dstg_t;

  dstg_t st_r [NW+1];
  logic [NW-1:0] na;
  logic [WordW-1:0] qfin;
  logic [NW-1:0]    qx;

  assign na = a[WordW-1] ? NW'(-(NW'(signed'(a)) <<< FRAC_BITS))
                         : NW'(NW'(a) << FRAC_BITS);

  always_ff @(posedge clk) begin
    st_r[0].n    <= na;
    st_r[0].r    <= '0;
    st_r[0].d    <= b[WordW-1] ? DW'(-b) : DW'(b);
    st_r[0].same <= (a[WordW-1] == b[WordW-1]) || (a == '0);
  end

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [RW-1:0] sh;
    logic [RW-1:0] df;
    assign sh = {st_r[i].r[RW-2:0], st_r[i].n[NW-1]};
    assign df = sh - {1'b0, st_r[i].d};
    always_ff @(posedge clk) begin
      st_r[i+1].d    <= st_r[i].d;
      st_r[i+1].same <= st_r[i].same;
      st_r[i+1].n    <= {st_r[i].n[NW-2:0], ~df[RW-1]};
      st_r[i+1].r    <= df[RW-1] ? sh : df;
    end
  end

  assign qx   = st_r[NW].n;
  assign qfin = st_r[NW].same ? WordW'(qx + NW'(st_r[NW].r != '0))
                              : WordW'(-qx);

  always_ff @(posedge clk) begin
    quot <= qfin;
  end
endmodule

### hw/rtl/fixed_point_alu_q24_8.sv
// ----------------------------------------------------------------------------
// Q24.8 fixed-point ALU
// Add, subtract, multiply, divide, min and max with compare flags.
// ----------------------------------------------------------------------------
// One transaction is taken per cycle: busy is tied low, so every start pulse
// is accepted. Each transaction returns exactly one result, strobed by
// out_valid for one cycle, in issue order, after the divider's input
// register, its stages (one quotient bit per stage) and output register. The
// receiver cannot stall; results are never held. Multiply and divide round
// toward plus infinity; all results wrap to 32 bits; divide by zero returns
// zero with the flag set; codes 6 and 7 return zero.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8 #(
  parameter int unsigned FRAC_BITS = fpalu_pkg::FracBitsD
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [fpalu_pkg::OpW-1:0]          in_operation,
  input  logic signed [fpalu_pkg::WordW-1:0] in_operand_a,
  input  logic signed [fpalu_pkg::WordW-1:0] in_operand_b,
  output logic                               out_valid,
  output logic signed [fpalu_pkg::WordW-1:0] out_result_value,
  output logic                               out_a_less,
  output logic                               out_a_equal,
  output logic                               out_a_greater,
  output logic                               out_divide_by_zero
);
  import fpalu_pkg::*;

  localparam int unsigned LATENCY = WordW + FRAC_BITS + 2;
  localparam int unsigned MULLAT  = 2;

  side_t          side;
  side_t          side_r [LATENCY];
  logic [LATENCY-1:0] vld_r;
  logic [WordW-1:0]   mul_res;
  logic [WordW-1:0]   div_res;
  logic [WordW-1:0]   mul_hold_r [LATENCY-MULLAT];
  logic [WordW-1:0]   res;
  side_t              tail;

  assign busy = 1'b0;

  // Compare flags and the simple, combinational operations up front.
  always_comb begin
    side    = '0;
    side.op = in_operation;
    side.lt = in_operand_a < in_operand_b;
    side.eq = in_operand_a == in_operand_b;
    side.gt = in_operand_a > in_operand_b;
    case (in_operation)
      OP_ADD: side.simple = in_operand_a + in_operand_b;
      OP_SUB: side.simple = in_operand_a - in_operand_b;
      OP_MIN: side.simple = side.lt ? in_operand_a : in_operand_b;
      OP_MAX: side.simple = side.gt ? in_operand_a : in_operand_b;
      default: side.simple = '0;
    endcase
    side.dz = (in_operation == OP_DIV) && (in_operand_b == '0);
  end

  fpalu_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk (clk), .a (in_operand_a), .b (in_operand_b), .prod (mul_res)
  );

  fpalu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk (clk), .a (in_operand_a), .b (in_operand_b), .quot (div_res)
  );

  // Advance valid bits and sideband beside the divider.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LATENCY-2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= side;
    for (int i = 1; i < LATENCY; i++) side_r[i] <= side_r[i-1];
    mul_hold_r[0] <= mul_res;
    for (int i = 1; i < LATENCY - MULLAT; i++) mul_hold_r[i] <= mul_hold_r[i-1];
  end

  assign tail = side_r[LATENCY-1];

  // Pick the finished result by operation.
  always_comb begin
    case (tail.op)
      OP_MUL:  res = mul_hold_r[LATENCY-MULLAT-1];
      OP_DIV:  res = tail.dz ? '0 : div_res;
      default: res = tail.simple;
    endcase
  end

  assign out_valid          = vld_r[LATENCY-1];
  assign out_result_value   = res;
  assign out_a_less         = tail.lt;
  assign out_a_equal        = tail.eq;
  assign out_a_greater      = tail.gt;
  assign out_divide_by_zero = tail.dz;

  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_a_less, out_a_equal, out_a_greater}))
    else $error("compare flags not one-hot");
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divide_by_zero) |-> (out_result_value == '0))
    else $error("divide by zero with nonzero result");
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");
endmodule
